[design/cpt_pkg.sv]
package cpt_pkg;

    // Coordinate and arithmetic widths
    localparam int CW    = 16;
    localparam int DIFW  = CW + 1;
    localparam int DOTW  = 2 * DIFW + 2;
    localparam int VW    = 2 * DOTW + 1;
    localparam int SW    = VW;
    localparam int DENW  = VW + 2;
    localparam int LOW   = (SW + 1) / 2;
    localparam int HIW   = SW - LOW;
    localparam int PLW   = LOW + 1 + DIFW;
    localparam int PHW   = HIW + DIFW;
    localparam int NUMW  = SW + DIFW + 1;
    localparam int REMW  = NUMW + 1;
    localparam int QW    = CW + 1;
    localparam int CMPW  = (REMW > DENW + 1 + QW) ? REMW : DENW + 1 + QW;
    localparam int RW    = QW + 2;
    localparam int QDEPTH = 4;
    localparam int QAW   = $clog2(QDEPTH);

    typedef logic [2:0][CW-1:0]   t_vec;
    typedef logic [2:0][DIFW-1:0] t_dvec;

    typedef enum logic [2:0] {
        REG_VERT_A   = 3'd0,
        REG_VERT_B   = 3'd1,
        REG_VERT_C   = 3'd2,
        REG_EDGE_AB  = 3'd3,
        REG_EDGE_AC  = 3'd4,
        REG_EDGE_BC  = 3'd5,
        REG_INTERIOR = 3'd6
    } t_region;

    // One classified request: start + round((s1*e1 + s2*e2) / den)
    typedef struct packed {
        t_region          region;
        t_vec             start;
        t_dvec            e1;
        t_dvec            e2;
        logic [SW-1:0]    s1;
        logic [SW-1:0]    s2;
        logic [DENW-1:0]  den;
    } t_job;

    // Sideband carried down the divider
    typedef struct packed {
        t_region          region;
        t_vec             start;
        logic [2:0]       neg;
        logic [2:0]       ovf;
        logic             zero;
        logic [DENW:0]    d2;
    } t_side;

    function automatic logic signed [DIFW-1:0] sx(input logic [CW-1:0] v);
        return $signed({v[CW-1], v});
    endfunction

endpackage

[design/cpt_front.sv]
module cpt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cpt_pkg::t_vec i_p,
    input  cpt_pkg::t_vec i_a,
    input  cpt_pkg::t_vec i_b,
    input  cpt_pkg::t_vec i_c,
    input  logic          i_full,
    output logic          o_push,
    output cpt_pkg::t_job o_job
);
    import cpt_pkg::*;

    logic en;
    logic r0_v, r1_v, r2_v;

    logic signed [DIFW-1:0] r0_ab [3], r0_ac [3], r0_bc [3];
    logic signed [DIFW-1:0] r0_ap [3], r0_bp [3], r0_cp [3];
    t_vec r0_a, r0_b;

    logic signed [DOTW-1:0] r1_d [6], n1_d [6];
    logic signed [DIFW-1:0] r1_ab [3], r1_ac [3], r1_bc [3];
    t_vec r1_a, r1_b;

    logic signed [2*DOTW-1:0] r2_p [6], n2_p [6];
    logic signed [DOTW-1:0]   r2_d [6];
    logic signed [DIFW-1:0]   r2_ab [3], r2_ac [3], r2_bc [3];
    t_vec r2_a, r2_b;

    // Advance the whole front unless a finished request cannot enter the queue
    assign en      = !r2_v || !i_full;
    assign o_ready = en;
    assign o_push  = r2_v && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_valid;
            r1_v <= r0_v;
            r2_v <= r1_v;
        end
    end

    // Stage 0: edge and offset vectors
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r0_ab[k] <= sx(i_b[k]) - sx(i_a[k]);
                r0_ac[k] <= sx(i_c[k]) - sx(i_a[k]);
                r0_bc[k] <= sx(i_c[k]) - sx(i_b[k]);
                r0_ap[k] <= sx(i_p[k]) - sx(i_a[k]);
                r0_bp[k] <= sx(i_p[k]) - sx(i_b[k]);
                r0_cp[k] <= sx(i_p[k]) - sx(i_c[k]);
            end
            r0_a <= i_a;
            r0_b <= i_b;
        end
    end

    // Stage 1: the six dot products d1..d6
    function automatic logic signed [DOTW-1:0] dot3(
        input logic signed [DIFW-1:0] u0, u1, u2, v0, v1, v2
    );
        logic signed [2*DIFW-1:0] t0, t1, t2;
        t0 = u0 * v0;
        t1 = u1 * v1;
        t2 = u2 * v2;
        return DOTW'(t0) + DOTW'(t1) + DOTW'(t2);
    endfunction

    always_comb begin
        n1_d[0] = dot3(r0_ab[0], r0_ab[1], r0_ab[2], r0_ap[0], r0_ap[1], r0_ap[2]);
        n1_d[1] = dot3(r0_ac[0], r0_ac[1], r0_ac[2], r0_ap[0], r0_ap[1], r0_ap[2]);
        n1_d[2] = dot3(r0_ab[0], r0_ab[1], r0_ab[2], r0_bp[0], r0_bp[1], r0_bp[2]);
        n1_d[3] = dot3(r0_ac[0], r0_ac[1], r0_ac[2], r0_bp[0], r0_bp[1], r0_bp[2]);
        n1_d[4] = dot3(r0_ab[0], r0_ab[1], r0_ab[2], r0_cp[0], r0_cp[1], r0_cp[2]);
        n1_d[5] = dot3(r0_ac[0], r0_ac[1], r0_ac[2], r0_cp[0], r0_cp[1], r0_cp[2]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d  <= n1_d;
            r1_ab <= r0_ab;
            r1_ac <= r0_ac;
            r1_bc <= r0_bc;
            r1_a  <= r0_a;
            r1_b  <= r0_b;
        end
    end

    // Stage 2: cross products of the dots for the barycentric numerators
    always_comb begin
        n2_p[0] = r1_d[0] * r1_d[3];
        n2_p[1] = r1_d[2] * r1_d[1];
        n2_p[2] = r1_d[4] * r1_d[1];
        n2_p[3] = r1_d[0] * r1_d[5];
        n2_p[4] = r1_d[2] * r1_d[5];
        n2_p[5] = r1_d[4] * r1_d[3];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_p  <= n2_p;
            r2_d  <= r1_d;
            r2_ab <= r1_ab;
            r2_ac <= r1_ac;
            r2_bc <= r1_bc;
            r2_a  <= r1_a;
            r2_b  <= r1_b;
        end
    end

    // Classify the region and form the request for the back end
    logic signed [VW-1:0]     va, vb, vc;
    logic signed [DOTW:0]     d43, d56;
    logic signed [DOTW-1:0]   d1, d2, d3, d4, d5, d6;
    t_dvec ab, ac, bc;

    function automatic logic le0(input logic msb, input logic nz);
        return msb || !nz;
    endfunction

    always_comb begin
        d1 = r2_d[0]; d2 = r2_d[1]; d3 = r2_d[2];
        d4 = r2_d[3]; d5 = r2_d[4]; d6 = r2_d[5];
        vc = VW'(r2_p[0]) - VW'(r2_p[1]);
        vb = VW'(r2_p[2]) - VW'(r2_p[3]);
        va = VW'(r2_p[4]) - VW'(r2_p[5]);
        d43 = (DOTW+1)'(d4) - (DOTW+1)'(d3);
        d56 = (DOTW+1)'(d5) - (DOTW+1)'(d6);
        for (int k = 0; k < 3; k++) begin
            ab[k] = r2_ab[k];
            ac[k] = r2_ac[k];
            bc[k] = r2_bc[k];
        end

        o_job.region = REG_VERT_A;
        o_job.start  = r2_a;
        o_job.e1     = '0;
        o_job.e2     = '0;
        o_job.s1     = '0;
        o_job.s2     = '0;
        o_job.den    = '0;

        if (le0(d1[DOTW-1], |d1) && le0(d2[DOTW-1], |d2)) begin
            o_job.region = REG_VERT_A;
        end else if (!d3[DOTW-1] && le0(d43[DOTW], |d43)) begin
            o_job.region = REG_VERT_B;
            o_job.start  = r2_b;
        end else if (!d6[DOTW-1] && le0(d56[DOTW], |d56)) begin
            o_job.region = REG_VERT_C;
            for (int k = 0; k < 3; k++) begin
                o_job.start[k] = CW'(r2_a[k] + r2_ac[k]);
            end
        end else if (le0(vc[VW-1], |vc) && !d1[DOTW-1] && le0(d3[DOTW-1], |d3)) begin
            o_job.region = REG_EDGE_AB;
            o_job.e1     = ab;
            o_job.s1     = SW'(d1);
            o_job.den    = DENW'(d1) - DENW'(d3);
        end else if (le0(vb[VW-1], |vb) && !d2[DOTW-1] && le0(d6[DOTW-1], |d6)) begin
            o_job.region = REG_EDGE_AC;
            o_job.e1     = ac;
            o_job.s1     = SW'(d2);
            o_job.den    = DENW'(d2) - DENW'(d6);
        end else if (le0(va[VW-1], |va) && !d43[DOTW] && !d56[DOTW]) begin
            o_job.region = REG_EDGE_BC;
            o_job.start  = r2_b;
            o_job.e1     = bc;
            o_job.s1     = SW'(d43);
            o_job.den    = DENW'(d43) + DENW'(d56);
        end else begin
            o_job.region = REG_INTERIOR;
            o_job.e1     = ab;
            o_job.e2     = ac;
            o_job.s1     = vb;
            o_job.s2     = vc;
            o_job.den    = DENW'(va) + DENW'(vb) + DENW'(vc);
        end
    end

endmodule

[design/cpt_queue.sv]
module cpt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cpt_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output cpt_pkg::t_job o_job
);
    import cpt_pkg::*;

    t_job             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QAW:0]     r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    // Hold pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store the incoming request
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

[design/cpt_back.sv]
module cpt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    output logic              o_pop,
    input  cpt_pkg::t_job     i_job,
    output logic              o_valid,
    input  logic              i_ready,
    output cpt_pkg::t_vec     o_near,
    output cpt_pkg::t_region  o_region
);
    import cpt_pkg::*;

    logic en;
    assign en    = !o_valid || i_ready;
    assign o_pop = en && !i_empty;

    // Stage 0: partial products of the scalars with the edge vectors
    logic                  r0_v;
    t_region               r0_region;
    t_vec                  r0_start;
    logic [DENW-1:0]       r0_den;
    logic signed [PLW-1:0] r0_pl [3][2];
    logic signed [PHW-1:0] r0_ph [3][2];

    logic signed [LOW:0]   sl1, sl2;
    logic signed [HIW-1:0] sh1, sh2;

    always_comb begin
        sl1 = $signed({1'b0, i_job.s1[LOW-1:0]});
        sl2 = $signed({1'b0, i_job.s2[LOW-1:0]});
        sh1 = $signed(i_job.s1[SW-1:LOW]);
        sh2 = $signed(i_job.s2[SW-1:LOW]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r0_pl[k][0] <= sl1 * $signed(i_job.e1[k]);
                r0_pl[k][1] <= sl2 * $signed(i_job.e2[k]);
                r0_ph[k][0] <= sh1 * $signed(i_job.e1[k]);
                r0_ph[k][1] <= sh2 * $signed(i_job.e2[k]);
            end
            r0_region <= i_job.region;
            r0_start  <= i_job.start;
            r0_den    <= i_job.den;
        end
    end

    // Stage 1: assemble the numerators
    logic                   r1_v;
    t_region                r1_region;
    t_vec                   r1_start;
    logic [DENW-1:0]        r1_den;
    logic signed [NUMW-1:0] r1_num [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r1_num[k] <= ((NUMW'(r0_ph[k][0]) + NUMW'(r0_ph[k][1])) <<< LOW)
                           + NUMW'(r0_pl[k][0]) + NUMW'(r0_pl[k][1]);
            end
            r1_region <= r0_region;
            r1_start  <= r0_start;
            r1_den    <= r0_den;
        end
    end

    // Stage 2: magnitudes, rounding offset and sign of each quotient
    logic              r2_v;
    t_region           r2_region;
    t_vec              r2_start;
    logic [REMW-1:0]   r2_n2 [3];
    logic [DENW:0]     r2_d2;
    logic [2:0]        r2_neg;
    logic              r2_zero;

    logic [NUMW-1:0]   an [3];
    logic [DENW-1:0]   ad;

    always_comb begin
        ad = r1_den[DENW-1] ? -r1_den : r1_den;
        for (int k = 0; k < 3; k++) begin
            an[k] = r1_num[k][NUMW-1] ? -r1_num[k] : r1_num[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r2_n2[k]  <= {an[k], 1'b0} + REMW'(ad);
                r2_neg[k] <= r1_num[k][NUMW-1] ^ r1_den[DENW-1];
            end
            r2_d2     <= {ad, 1'b0};
            r2_zero   <= (r1_den == '0);
            r2_region <= r1_region;
            r2_start  <= r1_start;
        end
    end

    // Stage 3: flag quotients too wide for the QW-bit quotient and load the divider
    logic            r_dv  [QW+1];
    t_side           r_sd  [QW+1];
    logic [REMW-1:0] r_rem [QW+1][3];
    logic [QW-1:0]   r_q   [QW+1][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_sd[0].ovf[k] <= (CMPW'(r2_n2[k]) >= (CMPW'(r2_d2) << QW));
                r_rem[0][k]    <= r2_n2[k];
                r_q[0][k]      <= '0;
            end
            r_sd[0].region <= r2_region;
            r_sd[0].start  <= r2_start;
            r_sd[0].neg    <= r2_neg;
            r_sd[0].zero   <= r2_zero;
            r_sd[0].d2     <= r2_d2;
        end
    end

    // Restoring divider: one quotient bit per stage, most significant first
    for (genvar g = 0; g < QW; g++) begin : g_div
        localparam int SH = QW - 1 - g;
        logic [CMPW-1:0] dd;
        assign dd = CMPW'(r_sd[g].d2) << SH;

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int k = 0; k < 3; k++) begin
                    if (CMPW'(r_rem[g][k]) >= dd) begin
                        r_rem[g+1][k]   <= REMW'(CMPW'(r_rem[g][k]) - dd);
                        r_q[g+1][k]     <= r_q[g][k] | (QW'(1) << SH);
                    end else begin
                        r_rem[g+1][k]   <= r_rem[g][k];
                        r_q[g+1][k]     <= r_q[g][k];
                    end
                end
                r_sd[g+1] <= r_sd[g];
            end
        end
    end

    // Valid flags along the back end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            for (int s = 0; s <= QW; s++) begin
                r_dv[s] <= 1'b0;
            end
        end else if (en) begin
            r0_v    <= !i_empty;
            r1_v    <= r0_v;
            r2_v    <= r1_v;
            r_dv[0] <= r2_v;
            for (int s = 0; s < QW; s++) begin
                r_dv[s+1] <= r_dv[s];
            end
        end
    end

    // Final: apply sign, add start vertex, saturate into the output register (a zero den passes the start vertex)
    localparam logic signed [RW-1:0] CMAX = RW'((1 << (CW - 1)) - 1);
    localparam logic signed [RW-1:0] CMIN = -CMAX - RW'(1);

    t_side                 fs;
    logic signed [RW-1:0]  qs [3], sum [3];
    t_vec                  n_near;
    logic                  r_out_v;
    t_vec                  r_near;
    t_region               r_region;

    always_comb begin
        fs = r_sd[QW];
        for (int k = 0; k < 3; k++) begin
            qs[k]  = fs.neg[k] ? -RW'(r_q[QW][k]) : RW'(r_q[QW][k]);
            sum[k] = RW'($signed(fs.start[k])) + qs[k];
            if (fs.zero) begin
                n_near[k] = fs.start[k];
            end else if (fs.ovf[k]) begin
                n_near[k] = fs.neg[k] ? CW'(CMIN) : CW'(CMAX);
            end else if (sum[k] > CMAX) begin
                n_near[k] = CW'(CMAX);
            end else if (sum[k] < CMIN) begin
                n_near[k] = CW'(CMIN);
            end else begin
                n_near[k] = CW'(sum[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_near   <= n_near;
            r_region <= fs.region;
        end
    end

    assign o_valid  = r_out_v;
    assign o_near   = r_near;
    assign o_region = r_region;

endmodule

[design/closest_point_on_triangle_core.sv]
// Pipeline: 3 front stages, the queue memory, 4 back stages, 17 divider stages, output.
// Throughput: one request per cycle while no back-pressure stalls it; the 17-stage
// restoring divider is pipelined one quotient bit per stage, and a 4-entry queue
// parts front and back.
// Reset: synchronous, active low; clears valid flags, queue pointers and the fill count only.
module closest_point_on_triangle_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // point_x, point_y, point_z, vert_a_x..z, vert_b_x..z, vert_c_x..z
    input  logic [191:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // near_x, near_y, near_z
    output logic [47:0]  m_axis_tdata,
    // region
    output logic [2:0]   m_axis_tuser
);
    import cpt_pkg::*;

    t_vec    p, a, b, c, near;
    t_job    push_job, pop_job;
    logic    push, pop, full, empty;
    t_region region;

    // Unpack the request coordinates
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            p[k] = s_axis_tdata[k*CW +: CW];
            a[k] = s_axis_tdata[(3+k)*CW +: CW];
            b[k] = s_axis_tdata[(6+k)*CW +: CW];
            c[k] = s_axis_tdata[(9+k)*CW +: CW];
        end
    end

    cpt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_p     (p),
        .i_a     (a),
        .i_b     (b),
        .i_c     (c),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    cpt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (pop_job)
    );

    cpt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .o_pop    (pop),
        .i_job    (pop_job),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_near   (near),
        .o_region (region)
    );

    assign m_axis_tdata = near;
    assign m_axis_tuser = region;

endmodule

[design/cpt_checker.sv]
module cpt_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [47:0]  m_axis_tdata,
    input logic [2:0]   m_axis_tuser
);
    import cpt_pkg::*;

    // Reset leaves no result pending
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Region code never takes the unused value
    a_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != 3'd7)
        else $error("region code out of range");

    // Nothing can come out at reset release or straight after it
    a_latency: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid ##1 !m_axis_tvalid)
        else $error("result too soon after reset");

endmodule

bind closest_point_on_triangle_core cpt_checker u_cpt_checker (.*);
